// ===== src/humidity_sensor_frame_decode_macros.svh =====
// Assertion macros for the humidity sensor frame decoder.
`ifndef HUMIDITY_SENSOR_FRAME_DECODE_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HSFD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsfd assertion failed");

// Invariant checked on every rising clock edge outside reset.
`define HSFD_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("hsfd invariant failed");

`endif

// ===== src/hsfd_pkg.sv =====
// Constants and helper functions for the humidity sensor frame decoder.
package hsfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam logic [23:0] TEMP_SPAN = 24'd175;
   localparam logic [23:0] HUM_SPAN  = 24'd100;
   localparam logic signed [8:0] TEMP_OFFSET = 9'sd45;

   // Byte positions within the six-byte frame
   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   // CRC-8, MSB first, no final xor
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   // floor(x / 65535), exact while the quotient stays below 256
   function automatic logic [8:0] div_full_scale(input logic [23:0] x);
      logic [24:0] s;
      s = {1'b0, x} + {17'd0, x[23:16]} + 25'd1;
      return s[24:16];
   endfunction

endpackage

// ===== src/humidity_sensor_frame_decode.sv =====
// Top level of the humidity sensor frame decoder.
// Decodes one six-byte measurement frame (temperature high, low, CRC, humidity
// high, low, CRC), taking one byte per beat on the req_ channel. Each word is
// checked with CRC-8 (poly 0x31, init 0xFF). After the sixth byte one result
// beat leaves on the rsp_ channel: temperature = raw*175/65535 - 45 and
// humidity = raw*100/65535, both truncated; status is 1 and both values are
// zero if either checksum failed. req_frame_start forces the byte to position
// zero and drops any partial frame. The block sustains one beat per cycle; the
// only stall is a sixth byte arriving while the previous result is still held
// in the single output register. rsp_valid rises in the cycle after the sixth
// byte is accepted.
`include "humidity_sensor_frame_decode_macros.svh"

module humidity_sensor_frame_decode
   import hsfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // byte input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_frame_start,
   // measurement result
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [8:0] rsp_temperature_c,
   output logic [6:0]        rsp_humidity_pct,
   output logic              rsp_status
);

   // frame state
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_raw_ff, temp_raw_in;
   logic [15:0] hum_raw_ff, hum_raw_in;
   logic        temp_ok_ff, temp_ok_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [8:0] temp_ff, temp_in;
   logic [6:0]        hum_ff, hum_in;
   logic              status_ff, status_in;

   logic [2:0]  cur_pos;
   logic        accept;
   logic        done_beat;
   logic [7:0]  crc_next;
   logic [23:0] temp_prod, hum_prod;
   logic [8:0]  temp_q, hum_q;
   logic        frame_ok;

   // Position of this byte: frame start or an out-of-range count means zero.
   assign cur_pos = (req_frame_start || (pos_ff > POS_H_CRC)) ? POS_T_HI : pos_ff;

   // Stall only when this byte closes a frame and the result slot is still full.
   assign req_ready = !rsp_valid_ff || rsp_ready || (cur_pos != POS_H_CRC);
   assign accept    = req_valid && req_ready;
   assign done_beat = accept && (cur_pos == POS_H_CRC);

   // Start-of-word bytes restart the CRC from its seed.
   assign crc_next = crc8_update(((cur_pos == POS_T_HI) || (cur_pos == POS_H_HI)) ?
                                 CRC_INIT : crc_ff, req_rx_byte);

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      hum_raw_in  = hum_raw_ff;
      temp_ok_in  = temp_ok_ff;
      if (accept) begin
         case (cur_pos)
            POS_T_HI: begin
               crc_in      = crc_next;
               temp_raw_in = {req_rx_byte, 8'h00};
               pos_in      = POS_T_LO;
            end
            POS_T_LO: begin
               crc_in      = crc_next;
               temp_raw_in = {temp_raw_ff[15:8], req_rx_byte};
               pos_in      = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_ok_in = (crc_ff == req_rx_byte);
               pos_in     = POS_H_HI;
            end
            POS_H_HI: begin
               crc_in     = crc_next;
               hum_raw_in = {req_rx_byte, 8'h00};
               pos_in     = POS_H_LO;
            end
            POS_H_LO: begin
               crc_in     = crc_next;
               hum_raw_in = {hum_raw_ff[15:8], req_rx_byte};
               pos_in     = POS_H_CRC;
            end
            default: begin
               pos_in = POS_T_HI;
            end
         endcase
      end
   end

   // Scaling: constant multiply, then divide by 65535 via add-and-shift.
   assign temp_prod = {8'd0, temp_raw_ff} * TEMP_SPAN;
   assign hum_prod  = {8'd0, hum_raw_ff} * HUM_SPAN;
   assign temp_q    = div_full_scale(temp_prod);
   assign hum_q     = div_full_scale(hum_prod);
   assign frame_ok  = temp_ok_ff && (crc_ff == req_rx_byte);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      status_in    = status_ff;
      if (done_beat) begin
         rsp_valid_in = 1'b1;
         if (frame_ok) begin
            temp_in   = $signed(temp_q) - TEMP_OFFSET;
            hum_in    = hum_q[6:0];
            status_in = 1'b0;
         end else begin
            temp_in   = '0;
            hum_in    = '0;
            status_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= CRC_INIT;
         temp_raw_ff  <= '0;
         hum_raw_ff   <= '0;
         temp_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_raw_ff  <= temp_raw_in;
         hum_raw_ff   <= hum_raw_in;
         temp_ok_ff   <= temp_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff   <= temp_in;
      hum_ff    <= hum_in;
      status_ff <= status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature_c = temp_ff;
   assign rsp_humidity_pct  = hum_ff;
   assign rsp_status        = status_ff;

   // checks
   `HSFD_ASSERT_ALWAYS(a_pos_range, pos_ff <= POS_H_CRC)
   `HSFD_ASSERT_IMP(a_rsp_from_frame_end, $rose(rsp_valid_ff), $past(done_beat))
   `HSFD_ASSERT_IMP(a_bad_frame_zero, rsp_valid_ff && status_ff, (temp_ff == '0) && (hum_ff == '0))
   `HSFD_ASSERT_IMP(a_hum_range, rsp_valid_ff && !status_ff, hum_ff <= 7'd100)

endmodule
